FILE: rtl/ppb_pkg.sv
// ============================================================================
// ppb_pkg - shared constants for the peak pyramid builder
// Default sizes, the Q7 peak width and the configuration reset value.
// ============================================================================
package ppb_pkg;

    // default pyramid depth and sample width
    localparam int PPB_LEVELS_DEF      = 16;
    localparam int PPB_SAMPLE_BITS_DEF = 16;

    // quantized peak width (Q7)
    localparam int PPB_Q_BITS = 8;

    // window length register
    localparam int              PPB_CFG_W    = 16;
    localparam logic [PPB_CFG_W-1:0] PPB_WS_RESET = 16'd256;

    // output beat: peak_min in the low byte, peak_max in the high byte
    localparam int PPB_OUT_DATA_W = 2 * PPB_Q_BITS;

endpackage

FILE: rtl/ppb_minmax.sv
// ============================================================================
// ppb_minmax - shared min/max merge unit
// Merges two signed (min, max) pairs: min of the mins, max of the maxes.
// Used for window accumulation and for merging peaks up the pyramid.
// ============================================================================
module ppb_minmax
    import ppb_pkg::*;
#(
    parameter int W = PPB_SAMPLE_BITS_DEF
)
(
    input  logic signed [W-1:0] a_lo,
    input  logic signed [W-1:0] a_hi,
    input  logic signed [W-1:0] b_lo,
    input  logic signed [W-1:0] b_hi,
    output logic signed [W-1:0] lo,
    output logic signed [W-1:0] hi
);

    // one compare per side
    assign lo = (a_lo < b_lo) ? a_lo : b_lo;
    assign hi = (a_hi > b_hi) ? a_hi : b_hi;

endmodule

FILE: rtl/ppb_pending.sv
// ============================================================================
// ppb_pending - pending peak store, one entry per pyramid level below the top
// Valid bits clear on reset; the min/max entries are only read while valid.
// ============================================================================
module ppb_pending
    import ppb_pkg::*;
#(
    parameter int LEVELS = PPB_LEVELS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [(((LEVELS - 1) > 1) ? $clog2(LEVELS - 1) : 1)-1:0] addr,
    input  logic                        wr_en,
    input  logic                        clr_en,
    input  logic signed [PPB_Q_BITS-1:0] wr_min,
    input  logic signed [PPB_Q_BITS-1:0] wr_max,
    output logic                        rd_valid,
    output logic signed [PPB_Q_BITS-1:0] rd_min,
    output logic signed [PPB_Q_BITS-1:0] rd_max,
    output logic                        any_valid
);

    localparam int DEPTH = LEVELS - 1;

    logic [DEPTH-1:0]                    valid_reg;
    logic signed [PPB_Q_BITS-1:0]        min_reg [DEPTH];
    logic signed [PPB_Q_BITS-1:0]        max_reg [DEPTH];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[addr] <= 1'b1;
        end
        else if (clr_en)
        begin
            valid_reg[addr] <= 1'b0;
        end
    end

    // peak payload, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            min_reg[addr] <= wr_min;
            max_reg[addr] <= wr_max;
        end
    end

    assign rd_valid  = valid_reg[addr];
    assign rd_min    = min_reg[addr];
    assign rd_max    = max_reg[addr];
    assign any_valid = |valid_reg;

endmodule

FILE: rtl/peak_pyramid_builder.sv
// ============================================================================
// peak_pyramid_builder - streaming min/max overview pyramid
// Level-0 peaks summarize windows of samples (quantized to Q7); each higher
// level pairs the peaks below it. Every peak formed is sent as one beat.
// ============================================================================
//
//  channel | dir | tdata                          | tuser  | tlast
//  --------+-----+--------------------------------+--------+--------------
//  s_*     | in  | sample [SAMPLE_BITS-1:0]       | -      | end_of_stream
//  m_*     | out | peak_min [7:0], peak_max [15:8]| level  | final_result
//  cfg_*   | in  | window_samples [15:0]          | -      | -
//
//  A sample that does not close a window only updates the running min/max.
//  A closing sample walks the levels with one merge per cycle through the
//  shared min/max unit while m_tready is high, at most one beat per level.
//  End of stream sends all LEVELS beats and clears the window and pending peaks.
//  A stalled output beat holds the sequencer; no sample is taken meanwhile.
//  Reset (rst_n, async) clears the window, all pending peaks and sets
//  window_samples to 256. A window length of zero acts as one.
//
module peak_pyramid_builder
    import ppb_pkg::*;
#(
    parameter int LEVELS      = PPB_LEVELS_DEF,
    parameter int SAMPLE_BITS = PPB_SAMPLE_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // sample stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata, // [SAMPLE_BITS-1:0] sample
    input  logic                      s_tlast,   // end_of_stream
    // peak stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [PPB_OUT_DATA_W-1:0] m_tdata,   // [7:0] peak_min, [15:8] peak_max
    output logic [$clog2(LEVELS)-1:0] m_tuser,   // level
    output logic                      m_tlast,   // final_result
    // window length register
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [PPB_CFG_W-1:0]      cfg_data
);

    localparam int LW        = $clog2(LEVELS);
    localparam int AW        = ((LEVELS - 1) > 1) ? $clog2(LEVELS - 1) : 1;
    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic                          state_reg, state_next;
    logic [PPB_CFG_W-1:0]          ws_reg;
    logic [PPB_CFG_W-1:0]          count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0] rmin_reg, rmin_next;
    logic signed [SAMPLE_BITS-1:0] rmax_reg, rmax_next;
    logic signed [PPB_Q_BITS-1:0]  cur_min_reg, cur_min_next;
    logic signed [PPB_Q_BITS-1:0]  cur_max_reg, cur_max_next;
    logic [LW-1:0]                 lvl_reg, lvl_next;
    logic                          eos_reg, eos_next;

    // shared unit and pending store hookups
    logic signed [SAMPLE_BITS-1:0] u_a_lo, u_a_hi, u_b_lo, u_b_hi, u_lo, u_hi;
    logic                          pend_wr, pend_clr, pend_valid, pend_any;
    logic signed [PPB_Q_BITS-1:0]  pend_min, pend_max;

    logic                          in_beat, out_beat, close_win;
    logic [PPB_CFG_W-1:0]          ws_eff, count_inc;
    logic signed [SAMPLE_BITS-1:0] sample;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign in_beat  = s_tvalid && s_tready;
    assign out_beat = m_tvalid && m_tready;

    ppb_minmax #(.W(SAMPLE_BITS)) u_minmax (
        .a_lo (u_a_lo),
        .a_hi (u_a_hi),
        .b_lo (u_b_lo),
        .b_hi (u_b_hi),
        .lo   (u_lo),
        .hi   (u_hi)
    );

    ppb_pending #(.LEVELS(LEVELS)) u_pending (
        .clk       (clk),
        .rst_n     (rst_n),
        .addr      (lvl_reg[AW-1:0]),
        .wr_en     (pend_wr),
        .clr_en    (pend_clr),
        .wr_min    (cur_min_reg),
        .wr_max    (cur_max_reg),
        .rd_valid  (pend_valid),
        .rd_min    (pend_min),
        .rd_max    (pend_max),
        .any_valid (pend_any)
    );

    // shared unit operands: window update when idle, peak merge when emitting
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            u_a_lo = sample;
            u_a_hi = sample;
            u_b_lo = rmin_reg;
            u_b_hi = rmax_reg;
        end
        else
        begin
            u_a_lo = SAMPLE_BITS'(pend_min);
            u_a_hi = SAMPLE_BITS'(pend_max);
            u_b_lo = SAMPLE_BITS'(cur_min_reg);
            u_b_hi = SAMPLE_BITS'(cur_max_reg);
        end
    end

    // window close test
    assign ws_eff    = (ws_reg == '0) ? PPB_CFG_W'(1) : ws_reg;
    assign count_inc = count_reg + PPB_CFG_W'(1);
    assign close_win = (count_inc >= ws_eff) || s_tlast;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rmin_next    = rmin_reg;
        rmax_next    = rmax_reg;
        cur_min_next = cur_min_reg;
        cur_max_next = cur_max_reg;
        lvl_next     = lvl_reg;
        eos_next     = eos_reg;
        pend_wr      = 1'b0;
        pend_clr     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (close_win)
                    begin
                        // quantize to Q7 by keeping the top byte
                        cur_min_next = u_lo[SAMPLE_BITS-1 -: PPB_Q_BITS];
                        cur_max_next = u_hi[SAMPLE_BITS-1 -: PPB_Q_BITS];
                        count_next   = '0;
                        rmin_next    = MOST_POS;
                        rmax_next    = MOST_NEG;
                        lvl_next     = '0;
                        eos_next     = s_tlast;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        count_next = count_inc;
                        rmin_next  = u_lo;
                        rmax_next  = u_hi;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_beat)
                begin
                    if (lvl_reg == LAST_LVL)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (pend_valid)
                    begin
                        // pair with the waiting peak and carry up
                        cur_min_next = u_lo[PPB_Q_BITS-1:0];
                        cur_max_next = u_hi[PPB_Q_BITS-1:0];
                        pend_clr     = 1'b1;
                        lvl_next     = lvl_reg + LW'(1);
                    end
                    else if (eos_reg)
                    begin
                        // flush: lone peak moves up alone
                        lvl_next = lvl_reg + LW'(1);
                    end
                    else
                    begin
                        // park the peak until its partner arrives
                        pend_wr    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ws_reg    <= PPB_WS_RESET;
            count_reg <= '0;
            rmin_reg  <= MOST_POS;
            rmax_reg  <= MOST_NEG;
            lvl_reg   <= '0;
            eos_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rmin_reg  <= rmin_next;
            rmax_reg  <= rmax_next;
            lvl_reg   <= lvl_next;
            eos_reg   <= eos_next;
            if (cfg_valid && cfg_ready)
            begin
                ws_reg <= cfg_data;
            end
        end
    end

    // current peak payload
    always_ff @(posedge clk)
    begin
        cur_min_reg <= cur_min_next;
        cur_max_reg <= cur_max_next;
    end

    // ports
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_EMIT);
    assign m_tdata   = {cur_max_reg, cur_min_reg};
    assign m_tuser   = lvl_reg;
    assign m_tlast   = eos_reg && (lvl_reg == LAST_LVL);
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[PPB_Q_BITS-1:0])
                      <= $signed(m_tdata[PPB_OUT_DATA_W-1:PPB_Q_BITS])))
        else $error("peak min above peak max");

    a_top_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && lvl_reg == LAST_LVL) |=> s_tready)
        else $error("sequencer did not return to idle after top level");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_beat && m_tlast) |=> (!pend_any && count_reg == '0))
        else $error("state not cleared after end of stream");

endmodule
